[src/srmst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmst_pkg
// Types, constants and helper functions shared by the square range maximum
// sparse table unit.
// ----------------------------------------------------------------------------
package srmst_pkg;

    localparam int MAX_SIDE_DEF = 512;
    localparam int LEVELS_DEF   = 10;

    localparam int DATA_W     = 32;
    localparam int ROW_W      = 9;
    localparam int SIZE_W     = 10;
    localparam int SIDE_CFG_W = 10;
    localparam int LOG_W      = 4;

    localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RST = SIDE_CFG_W'(1);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_DRAIN,
        ST_QUERY,
        ST_LAST,
        ST_DONE
    } t_state;

    function automatic logic [LOG_W-1:0] floor_log2(input logic [SIZE_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int b = 0; b < SIZE_W; b++) begin
            if (v[b]) begin
                r = LOG_W'(b);
            end
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

[src/srmst_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmst_item_if / srmst_result_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface srmst_item_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic [srmst_pkg::ROW_W-1:0]            row;
    logic [srmst_pkg::ROW_W-1:0]            col;
    logic signed [srmst_pkg::DATA_W-1:0]    cell_value;
    logic [srmst_pkg::SIZE_W-1:0]           square_size;

    modport source (
        output valid, action, row, col, cell_value, square_size,
        input  ready
    );
    modport sink (
        input  valid, action, row, col, cell_value, square_size,
        output ready
    );
endinterface

interface srmst_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [srmst_pkg::DATA_W-1:0]    max_value;
    logic                                   bad_query;

    modport source (
        output valid, max_value, bad_query,
        input  ready
    );
    modport sink (
        input  valid, max_value, bad_query,
        output ready
    );
endinterface

[src/srmst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmst_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module srmst_ram #(
    parameter int WIDTH = srmst_pkg::DATA_W,
    parameter int DEPTH = srmst_pkg::LEVELS_DEF * srmst_pkg::MAX_SIDE_DEF
                          * srmst_pkg::MAX_SIDE_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/square_range_max_sparse_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_range_max_sparse_table_unit
// Square-window maximum over a grid held in a two-dimensional sparse table.
// ----------------------------------------------------------------------------
// All table levels live in one RAM of LEVELS * 4^ceil(log2 MAX_SIDE) words
// with a single read port and a registered read; the RAM is never cleared, so
// every cell must be loaded before a query covers it. A load is written as it
// is accepted and the next item is accepted in the following cycle. A query on
// a current table passes through acceptance, four table reads through the one
// read port, and the final maximum into the output register. The first query
// after any in-grid load or grid_side write first rebuilds the table: for each
// entry of every level k >= 1 with 2^k <= N and k < LEVELS it reads four
// entries of level k-1, and a drain state finishes the last write. Rejected
// queries skip the rebuild and go straight to the done state. The result
// register lets a new item be accepted while a result still waits to be taken.
// ----------------------------------------------------------------------------
module square_range_max_sparse_table_unit #(
    parameter int MAX_SIDE = srmst_pkg::MAX_SIDE_DEF,
    parameter int LEVELS   = srmst_pkg::LEVELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srmst_pkg::SIDE_CFG_W-1:0]  i_cfg_wdata,
    srmst_item_if.sink                        i_item,
    srmst_result_if.source                    o_result
);

    localparam int DW     = srmst_pkg::DATA_W;
    localparam int SIDE_W = $clog2(MAX_SIDE);
    localparam int LW     = $clog2(LEVELS);
    localparam int AW     = LW + 2 * SIDE_W;
    localparam int DEPTH  = LEVELS << (2 * SIDE_W);
    localparam int CW0    = (SIDE_W > LEVELS) ? SIDE_W : LEVELS;
    localparam int CW     = ((CW0 > srmst_pkg::SIDE_CFG_W) ? CW0 : srmst_pkg::SIDE_CFG_W) + 2;

    srmst_pkg::t_state r_state, n_state;

    logic [srmst_pkg::SIDE_CFG_W-1:0] r_grid_side, n_grid_side;
    logic                  r_stale, n_stale;
    logic [LW-1:0]         r_k, n_k;
    logic [SIDE_W-1:0]     r_i, n_i;
    logic [SIDE_W-1:0]     r_j, n_j;
    logic [1:0]            r_phase, n_phase;
    logic                  r_rd_valid, n_rd_valid;
    logic [1:0]            r_rd_phase, n_rd_phase;
    logic                  r_rd_build, n_rd_build;
    logic [AW-1:0]         r_wr_addr, n_wr_addr;
    logic signed [DW-1:0]  r_acc, n_acc;
    logic [SIDE_W-1:0]     r_row, n_row;
    logic [SIDE_W-1:0]     r_col, n_col;
    logic [SIDE_W-1:0]     r_off, n_off;
    logic [LW-1:0]         r_kq, n_kq;
    logic                  r_bad, n_bad;
    logic                  r_out_valid, n_out_valid;
    logic signed [DW-1:0]  r_out_max, n_out_max;
    logic                  r_out_bad, n_out_bad;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DW-1:0]         ram_rdata;

    logic [srmst_pkg::SIDE_CFG_W-1:0] w_n;
    logic signed [DW-1:0]  w_rdata;
    logic signed [DW-1:0]  w_merged;
    logic [CW-1:0]         w_span;
    logic [CW-1:0]         w_half;
    logic [srmst_pkg::LOG_W-1:0] w_lg;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_bad;

    srmst_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_n      = (32'(r_grid_side) > MAX_SIDE) ? srmst_pkg::SIDE_CFG_W'(MAX_SIDE)
                                                    : r_grid_side;
    assign w_rdata  = ram_rdata;
    assign w_merged = srmst_pkg::smax(r_acc, w_rdata);
    assign w_span   = CW'(1) << r_k;
    assign w_half   = w_span >> 1;
    assign w_lg     = srmst_pkg::floor_log2(i_item.square_size);

    assign i_item.ready = (r_state == srmst_pkg::ST_IDLE);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;

    assign w_bad = (i_item.square_size == '0)
                || (CW'(i_item.row) + CW'(i_item.square_size) > CW'(w_n))
                || (CW'(i_item.col) + CW'(i_item.square_size) > CW'(w_n))
                || (int'(w_lg) >= LEVELS);

    assign o_result.valid     = r_out_valid;
    assign o_result.max_value = r_out_max;
    assign o_result.bad_query = r_out_bad;

    always_comb begin
        n_state     = r_state;
        n_grid_side = r_grid_side;
        n_stale     = r_stale;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_phase     = r_phase;
        n_rd_valid  = 1'b0;
        n_rd_phase  = r_phase;
        n_rd_build  = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_acc       = r_acc;
        n_row       = r_row;
        n_col       = r_col;
        n_off       = r_off;
        n_kq        = r_kq;
        n_bad       = r_bad;
        n_out_valid = (r_out_valid && o_result.ready) ? 1'b0 : r_out_valid;
        n_out_max   = r_out_max;
        n_out_bad   = r_out_bad;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        if (r_rd_valid) begin
            n_acc = (r_rd_phase == 2'd0) ? w_rdata : w_merged;
            if (r_rd_build && (r_rd_phase == 2'd3)) begin
                ram_we    = 1'b1;
                ram_waddr = r_wr_addr;
                ram_wdata = w_merged;
            end
        end

        unique case (r_state)
            srmst_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.action == srmst_pkg::ACT_LOAD) begin
                        if ((CW'(i_item.row) < CW'(w_n)) && (CW'(i_item.col) < CW'(w_n))) begin
                            ram_we    = 1'b1;
                            ram_waddr = {LW'(0), SIDE_W'(i_item.row), SIDE_W'(i_item.col)};
                            ram_wdata = i_item.cell_value;
                            n_stale   = 1'b1;
                        end
                    end else begin
                        n_row   = SIDE_W'(i_item.row);
                        n_col   = SIDE_W'(i_item.col);
                        n_kq    = LW'(w_lg);
                        n_off   = SIDE_W'(i_item.square_size
                                          - (srmst_pkg::SIZE_W'(1) << w_lg));
                        n_phase = 2'd0;
                        if (w_bad) begin
                            n_bad   = 1'b1;
                            n_acc   = '0;
                            n_state = srmst_pkg::ST_DONE;
                        end else begin
                            n_bad = 1'b0;
                            if (r_stale) begin
                                n_stale = 1'b0;
                                n_k     = LW'(1);
                                n_i     = '0;
                                n_j     = '0;
                                n_state = (CW'(w_n) >= CW'(2)) ? srmst_pkg::ST_BUILD
                                                               : srmst_pkg::ST_QUERY;
                            end else begin
                                n_state = srmst_pkg::ST_QUERY;
                            end
                        end
                    end
                end
            end
            srmst_pkg::ST_BUILD: begin
                ram_raddr  = {r_k - LW'(1),
                              SIDE_W'(CW'(r_i) + (r_phase[0] ? w_half : CW'(0))),
                              SIDE_W'(CW'(r_j) + (r_phase[1] ? w_half : CW'(0)))};
                n_rd_valid = 1'b1;
                n_rd_build = 1'b1;
                n_phase    = r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    n_wr_addr = {r_k, r_i, r_j};
                    if (CW'(r_j) + CW'(1) + w_span <= CW'(w_n)) begin
                        n_j = r_j + SIDE_W'(1);
                    end else if (CW'(r_i) + CW'(1) + w_span <= CW'(w_n)) begin
                        n_j = '0;
                        n_i = r_i + SIDE_W'(1);
                    end else if ((int'(r_k) + 1 < LEVELS) && ((w_span << 1) <= CW'(w_n))) begin
                        n_j = '0;
                        n_i = '0;
                        n_k = r_k + LW'(1);
                    end else begin
                        n_state = srmst_pkg::ST_DRAIN;
                    end
                end
            end
            srmst_pkg::ST_DRAIN: begin
                n_state = srmst_pkg::ST_QUERY;
            end
            srmst_pkg::ST_QUERY: begin
                ram_raddr  = {r_kq,
                              r_row + (r_phase[0] ? r_off : SIDE_W'(0)),
                              r_col + (r_phase[1] ? r_off : SIDE_W'(0))};
                n_rd_valid = 1'b1;
                n_phase    = r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    n_state = srmst_pkg::ST_LAST;
                end
            end
            srmst_pkg::ST_LAST: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_max   = w_merged;
                    n_out_bad   = 1'b0;
                    n_state     = srmst_pkg::ST_IDLE;
                end else begin
                    n_state = srmst_pkg::ST_DONE;
                end
            end
            srmst_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_max   = r_acc;
                    n_out_bad   = r_bad;
                    n_state     = srmst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srmst_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_grid_side = i_cfg_wdata;
            n_stale     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srmst_pkg::ST_IDLE;
            r_grid_side <= srmst_pkg::GRID_SIDE_RST;
            r_stale     <= 1'b1;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grid_side <= n_grid_side;
            r_stale     <= n_stale;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_i        <= n_i;
        r_j        <= n_j;
        r_phase    <= n_phase;
        r_rd_phase <= n_rd_phase;
        r_rd_build <= n_rd_build;
        r_wr_addr  <= n_wr_addr;
        r_acc      <= n_acc;
        r_row      <= n_row;
        r_col      <= n_col;
        r_off      <= n_off;
        r_kq       <= n_kq;
        r_bad      <= n_bad;
        r_out_max  <= n_out_max;
        r_out_bad  <= n_out_bad;
    end

endmodule

[verif/srmst_window_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srmst_window_checker
// Watches the configuration port and both channels of the square range maximum
// unit. It keeps its own copy of the grid, works out the window maximum of
// every accepted query and compares each result item, in order, with it.
// ----------------------------------------------------------------------------
module srmst_window_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srmst_pkg::SIDE_CFG_W-1:0]  i_cfg_wdata,
    srmst_item_if                             i_item,
    srmst_result_if                           i_result,
    output int unsigned                       o_fail_count,
    output int unsigned                       o_pending,
    output int unsigned                       o_results,
    output int unsigned                       o_rejected
);

    localparam int          DATA_W      = srmst_pkg::DATA_W;
    localparam int          SIDE_CFG_W  = srmst_pkg::SIDE_CFG_W;
    localparam int unsigned GRID_MAX    = srmst_pkg::MAX_SIDE_DEF;
    localparam int unsigned LEVEL_COUNT = srmst_pkg::LEVELS_DEF;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic                     bad_query;
    } t_window_result;

    logic signed [DATA_W-1:0] grid_cells [GRID_MAX][GRID_MAX];
    logic [SIDE_CFG_W-1:0]    grid_side;
    t_window_result           awaited_q [$];
    int unsigned              fail_count;
    int unsigned              result_count;
    int unsigned              reject_count;

    function automatic int unsigned active_side();
        return (grid_side > GRID_MAX) ? GRID_MAX : int'(grid_side);
    endfunction

    function automatic t_window_result square_max(input int unsigned row0,
                                                  input int unsigned col0,
                                                  input int unsigned span);
        t_window_result           res;
        logic signed [DATA_W-1:0] best;
        int unsigned              n;
        n = active_side();
        res.max_value = '0;
        res.bad_query = 1'b1;
        if (span == 0 || row0 + span > n || col0 + span > n ||
            span >= (1 << LEVEL_COUNT)) begin
            return res;
        end
        best = grid_cells[row0][col0];
        for (int unsigned r = row0; r < row0 + span; r++) begin
            for (int unsigned c = col0; c < col0 + span; c++) begin
                if (grid_cells[r][c] > best) begin
                    best = grid_cells[r][c];
                end
            end
        end
        res.max_value = best;
        res.bad_query = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_window_result want;
        t_window_result got;
        if (!i_rst_n) begin
            grid_side = srmst_pkg::GRID_SIDE_RST;
            for (int unsigned r = 0; r < GRID_MAX; r++) begin
                for (int unsigned c = 0; c < GRID_MAX; c++) begin
                    grid_cells[r][c] = '0;
                end
            end
            awaited_q.delete();
            fail_count   = 0;
            result_count = 0;
            reject_count = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.max_value = i_result.max_value;
                got.bad_query = i_result.bad_query;
                result_count++;
                if (awaited_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result item with none expected, got %0d bad_query %0b",
                             $time, $signed(got.max_value), got.bad_query);
                end else begin
                    want = awaited_q.pop_front();
                    if (want.max_value !== got.max_value) begin
                        fail_count++;
                        $display("%0t: max_value mismatch, expected %0d, got %0d",
                                 $time, $signed(want.max_value), $signed(got.max_value));
                    end
                    if (want.bad_query !== got.bad_query) begin
                        fail_count++;
                        $display("%0t: bad_query mismatch, expected %0b, got %0b",
                                 $time, want.bad_query, got.bad_query);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.action == srmst_pkg::ACT_LOAD) begin
                    if (i_item.row < active_side() && i_item.col < active_side()) begin
                        grid_cells[i_item.row][i_item.col] = i_item.cell_value;
                    end
                end else begin
                    want = square_max(i_item.row, i_item.col, i_item.square_size);
                    if (want.bad_query) begin
                        reject_count++;
                    end
                    awaited_q = {awaited_q, want};
                end
            end
            if (i_cfg_we) begin
                grid_side = i_cfg_wdata;
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_q.size();
        o_results    <= result_count;
        o_rejected   <= reject_count;
    end

endmodule

[verif/tb_square_range_max_sparse_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_range_max_sparse_table_unit
// Drives loads, queries and grid side writes into the square range maximum
// unit, with random gaps on both channels and one long hold on the result
// side. A short directed sequence covers the field extremes and the corner
// cases; random phases over many grid sides follow. The window checker
// predicts and compares every result item; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_square_range_max_sparse_table_unit;

    localparam int          DATA_W        = srmst_pkg::DATA_W;
    localparam int          ROW_W         = srmst_pkg::ROW_W;
    localparam int          SIZE_W        = srmst_pkg::SIZE_W;
    localparam int          SIDE_CFG_W    = srmst_pkg::SIDE_CFG_W;
    localparam int unsigned CLK_HALF      = 4;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned PLANNED_ITEMS = 1800;
    localparam int unsigned PHASE_ITEMS   = 145;
    localparam int unsigned WIDE_ITEMS    = 30;
    localparam int unsigned HOLD_AT       = 40;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned GRID_MAX      = srmst_pkg::MAX_SIDE_DEF;
    localparam int unsigned SIZE_MAX      = (1 << SIZE_W) - 1;
    localparam int unsigned SIDE_CFG_MAX  = (1 << SIDE_CFG_W) - 1;
    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [SIDE_CFG_W-1:0] i_cfg_wdata;

    srmst_item_if   items ();
    srmst_result_if results ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_seen;
    int unsigned rejected;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned side_writes;
    int unsigned side;
    int unsigned cycle_count = 0;
    bit          cell_loaded [GRID_MAX][GRID_MAX];
    int unsigned grid_plan [12] = '{1, 3, 2, 5, 4, 8, 6, 11, 7, 16, 9, 13};

    square_range_max_sparse_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (items),
        .o_result    (results)
    );

    srmst_window_checker window_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (items),
        .i_result     (results),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_rejected   (rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold once the first
    // few dozen results have gone through.
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        results.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                results.ready <= 1'b0;
            end else if (hold_left > 0) begin
                results.ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                results.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                results.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: begin
                return MOST_NEG;
            end
            1: begin
                return MOST_POS;
            end
            2: begin
                return int'($urandom_range(0, 8)) - 4;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic int unsigned reject_size(input int unsigned r, input int unsigned c,
                                                input int unsigned n);
        int unsigned sz;
        sz = $urandom_range(0, SIZE_MAX);
        if (sz != 0 && r + sz <= n && c + sz <= n) begin
            sz = n + 1 - r;
        end
        return sz;
    endfunction

    task automatic push_item(input logic act, input int unsigned r, input int unsigned c,
                             input logic signed [DATA_W-1:0] v, input int unsigned sz);
        if (items_sent < PLANNED_ITEMS / 3) begin
            send_idle_pct = 17;
            recv_idle_pct <= 86;
        end else if (items_sent < 2 * PLANNED_ITEMS / 3) begin
            send_idle_pct = 86;
            recv_idle_pct <= 17;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            items.valid <= 1'b0;
            @(posedge i_clk);
        end
        items.valid       <= 1'b1;
        items.action      <= act;
        items.row         <= ROW_W'(r);
        items.col         <= ROW_W'(c);
        items.cell_value  <= v;
        items.square_size <= SIZE_W'(sz);
        @(posedge i_clk);
        while (!items.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_load(input int unsigned r, input int unsigned c,
                             input logic signed [DATA_W-1:0] v);
        int unsigned eff;
        eff = (side > GRID_MAX) ? GRID_MAX : side;
        if (r < eff && c < eff) begin
            cell_loaded[r][c] = 1'b1;
        end
        push_item(srmst_pkg::ACT_LOAD, r, c, v, $urandom_range(0, SIZE_MAX));
    endtask

    task automatic send_query(input int unsigned r, input int unsigned c,
                              input int unsigned sz);
        push_item(srmst_pkg::ACT_QUERY, r, c, $urandom, sz);
    endtask

    task automatic write_side(input int unsigned new_side);
        items.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= SIDE_CFG_W'(new_side);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        side = new_side;
        side_writes++;
    endtask

    task automatic run_grid_phase(input int unsigned n);
        int unsigned r;
        int unsigned c;
        int unsigned sz;
        int unsigned swap;
        int unsigned done;
        write_side(n);
        done = 0;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                if (!cell_loaded[r][c]) begin
                    send_load(r, c, pick_value());
                    done++;
                end
            end
        end
        while (done < PHASE_ITEMS) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = $urandom_range(0, GRID_MAX - 1);
                    c = $urandom_range(0, GRID_MAX - 1);
                    send_query(r, c, reject_size(r, c, n));
                end else begin
                    sz = $urandom_range(1, n);
                    send_query($urandom_range(0, n - sz), $urandom_range(0, n - sz), sz);
                end
                done++;
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = $urandom_range(n, GRID_MAX - 1);
                    c = $urandom_range(0, GRID_MAX - 1);
                    swap = $urandom_range(0, 1);
                    if (swap != 0) begin
                        send_load(c, r, pick_value());
                    end else begin
                        send_load(r, c, pick_value());
                    end
                end else begin
                    send_load($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_value());
                    done++;
                end
            end
        end
    endtask

    // Wide grids are never fully loaded, so only loads and rejected queries.
    task automatic run_wide_phase(input int unsigned new_side);
        int unsigned r;
        int unsigned c;
        write_side(new_side);
        repeat (WIDE_ITEMS) begin
            r = $urandom_range(0, GRID_MAX - 1);
            c = $urandom_range(0, GRID_MAX - 1);
            if ($urandom_range(0, 1) == 0) begin
                send_load(r, c, pick_value());
            end else begin
                send_query(r, c, reject_size(r, c, GRID_MAX));
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        items.valid       = 1'b0;
        items.action      = srmst_pkg::ACT_LOAD;
        items.row         = '0;
        items.col         = '0;
        items.cell_value  = '0;
        items.square_size = '0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        items_sent        = 0;
        side_writes       = 0;
        side              = srmst_pkg::GRID_SIDE_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-cell grid straight out of reset.
        send_load(0, 0, MOST_NEG);
        send_query(0, 0, 1);
        send_query(0, 0, 0);
        send_load(0, 1, 5);
        send_query(0, 0, 1);

        // Empty grid: loads are dropped and every query is rejected.
        write_side(0);
        send_load(0, 0, MOST_POS);
        send_query(0, 0, 1);

        write_side(2);
        send_load(0, 0, MOST_POS);
        send_load(0, 1, -1);
        send_load(1, 0, 0);
        send_load(1, 1, MOST_NEG);
        send_query(0, 0, 2);
        send_query(1, 1, 1);
        send_query(1, 0, 2);
        send_load(0, 0, 7);
        send_query(0, 0, 2);
        send_query(GRID_MAX - 1, GRID_MAX - 1, SIZE_MAX);

        // An oversized side behaves as the largest grid.
        write_side(SIDE_CFG_MAX);
        send_load(GRID_MAX - 1, GRID_MAX - 1, 1234);
        send_query(0, 0, 600);
        send_query(GRID_MAX - 1, GRID_MAX - 1, 2);
        send_query(1, 0, GRID_MAX);

        foreach (grid_plan[i]) begin
            if (i == 6) begin
                run_wide_phase(GRID_MAX);
            end
            run_grid_phase(grid_plan[i]);
        end
        run_wide_phase(SIDE_CFG_MAX);

        items.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items under %0d grid side writes, sides 0 to %0d included.",
                 items_sent, side_writes, SIDE_CFG_MAX);
        $display("Checked %0d results, %0d of them rejected queries; %0d mismatches.",
                 results_seen, rejected, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
